// File: rtl/bfha_pkg.sv
package bfha_pkg;

    // Status codes returned with each result
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_NO_BLOCK = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam int PG_W = 5;

    typedef logic [4:0] t_op;

    // Sequencer steps; the controller state is the command it issues
    localparam t_op OP_IDLE     = 5'd0;
    localparam t_op OP_INIT     = 5'd1;
    localparam t_op OP_A_RD     = 5'd2;
    localparam t_op OP_A_CMP    = 5'd3;
    localparam t_op OP_G_SETUP  = 5'd4;
    localparam t_op OP_G_STEP   = 5'd5;
    localparam t_op OP_G_FREE   = 5'd6;
    localparam t_op OP_G_NEW    = 5'd7;
    localparam t_op OP_USE      = 5'd8;
    localparam t_op OP_SH_RD    = 5'd9;
    localparam t_op OP_SH_WR    = 5'd10;
    localparam t_op OP_INS_WR   = 5'd11;
    localparam t_op OP_F_RD     = 5'd12;
    localparam t_op OP_F_CMP    = 5'd13;
    localparam t_op OP_N_RD     = 5'd14;
    localparam t_op OP_N_CAP    = 5'd15;
    localparam t_op OP_MERGE    = 5'd16;
    localparam t_op OP_RM_RD    = 5'd17;
    localparam t_op OP_RM_WR    = 5'd18;
    localparam t_op OP_RM_END   = 5'd19;
    localparam t_op OP_SK_RD    = 5'd20;
    localparam t_op OP_SK_CMP   = 5'd21;
    localparam t_op OP_PG_STEP  = 5'd22;
    localparam t_op OP_TR_CHK   = 5'd23;
    localparam t_op OP_TR_JOIN  = 5'd24;
    localparam t_op OP_FAIL_NS  = 5'd25;
    localparam t_op OP_FAIL_NB  = 5'd26;
    localparam t_op OP_DONE     = 5'd27;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic found;
        logic lst_used;
        logic tbl_full;
        logic a_last;
        logic g_enough;
        logic g_over;
        logic split;
        logic sh_more;
        logic match;
        logic rm_more;
        logic sk_back;
        logic pg_more;
        logic tr_skip;
        logic tr_big;
    } t_stat;

endpackage

// File: rtl/bfha_ram.sv
module bfha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/bfha_ctrl.sv
module bfha_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_action,
    input  bfha_pkg::t_stat i_stat,
    output bfha_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_done
);
    import bfha_pkg::*;

    t_op r_state;
    t_op n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= OP_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            OP_INIT:    n_state = OP_IDLE;
            OP_IDLE: begin
                if (i_start) begin
                    n_state = (i_action == ACT_FREE) ? OP_F_RD : OP_A_RD;
                end
            end
            OP_A_RD:    n_state = OP_A_CMP;
            OP_A_CMP:   n_state = i_stat.a_last ? OP_G_SETUP : OP_A_RD;
            OP_G_SETUP: begin
                if (i_stat.found) begin
                    n_state = OP_USE;
                end else if (i_stat.lst_used && i_stat.tbl_full) begin
                    n_state = OP_FAIL_NS;
                end else begin
                    n_state = OP_G_STEP;
                end
            end
            OP_G_STEP: begin
                if (i_stat.g_enough) begin
                    n_state = i_stat.lst_used ? OP_G_NEW : OP_G_FREE;
                end else if (i_stat.g_over) begin
                    n_state = OP_FAIL_NS;
                end
            end
            OP_G_FREE:  n_state = OP_USE;
            OP_G_NEW:   n_state = OP_USE;
            OP_USE:     n_state = i_stat.split ? OP_SH_RD : OP_DONE;
            OP_SH_RD:   n_state = i_stat.sh_more ? OP_SH_WR : OP_INS_WR;
            OP_SH_WR:   n_state = OP_SH_RD;
            OP_INS_WR:  n_state = OP_DONE;
            OP_F_RD:    n_state = OP_F_CMP;
            OP_F_CMP: begin
                if (i_stat.match) begin
                    n_state = OP_N_RD;
                end else if (i_stat.a_last) begin
                    n_state = OP_FAIL_NB;
                end else begin
                    n_state = OP_F_RD;
                end
            end
            OP_N_RD:    n_state = OP_N_CAP;
            OP_N_CAP:   n_state = OP_MERGE;
            OP_MERGE:   n_state = OP_RM_RD;
            OP_RM_RD:   n_state = i_stat.rm_more ? OP_RM_WR : OP_RM_END;
            OP_RM_WR:   n_state = OP_RM_RD;
            OP_RM_END:  n_state = OP_SK_RD;
            OP_SK_RD:   n_state = OP_SK_CMP;
            OP_SK_CMP:  n_state = i_stat.sk_back ? OP_SK_RD : OP_PG_STEP;
            OP_PG_STEP: n_state = i_stat.pg_more ? OP_PG_STEP : OP_TR_CHK;
            OP_TR_CHK:  n_state = (i_stat.tr_skip || i_stat.tr_big) ? OP_DONE : OP_TR_JOIN;
            OP_TR_JOIN: n_state = OP_DONE;
            OP_FAIL_NS: n_state = OP_DONE;
            OP_FAIL_NB: n_state = OP_DONE;
            OP_DONE:    n_state = OP_IDLE;
            default:    n_state = OP_IDLE;
        endcase
    end

    assign o_cmd.op = r_state;
    assign o_busy   = (r_state != OP_IDLE);
    assign o_done   = (r_state == OP_DONE);
endmodule

// File: rtl/bfha_dp.sv
module bfha_dp #(
    parameter int PAGE_BYTES     = 4096,
    parameter int MAX_PAGES      = 16,
    parameter int MAX_BLOCKS     = 64,
    parameter int BLOCK_OVERHEAD = 32,
    parameter int HEAD_OVERHEAD  = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bfha_pkg::t_cmd             i_cmd,
    output bfha_pkg::t_stat            o_stat,
    input  logic                       i_cfg_we,
    input  logic [4:0]                 i_cfg_data,
    input  logic [15:0]                i_request_bytes,
    input  logic [15:0]                i_free_offset,
    output logic [1:0]                 o_status,
    output logic [15:0]                o_payload_offset,
    output logic [bfha_pkg::PG_W-1:0]  o_pages_in_use,
    output logic [6:0]                 o_blocks_in_table
);
    import bfha_pkg::*;

    localparam int SPAN_W = $clog2(PAGE_BYTES * MAX_PAGES);
    localparam int VW     = ((SPAN_W > 17) ? SPAN_W : 17) + 2;
    localparam int EW     = 2 * VW + 1;
    localparam int IW     = $clog2(MAX_BLOCKS);
    localparam int TW     = $clog2(MAX_BLOCKS + 1);

    localparam logic [VW-1:0] C_PAGE = VW'(PAGE_BYTES);
    localparam logic [VW-1:0] C_BO   = VW'(BLOCK_OVERHEAD);
    localparam logic [VW-1:0] C_HEAD = VW'(HEAD_OVERHEAD);
    localparam logic [VW-1:0] C_RND  = VW'(7);
    localparam logic [TW-1:0] C_MAXB = TW'(MAX_BLOCKS);
    localparam logic [5:0]    C_MAXP = 6'(MAX_PAGES);

    logic [TW-1:0]   r_total, r_i, r_best, r_sk;
    logic [PG_W-1:0] r_pages, r_k, r_limit;
    logic [VW-1:0]   r_span_end, r_size, r_need, r_acc, r_new_end;
    logic [15:0]     r_off;
    logic            r_found;
    logic [VW-1:0]   r_best_start, r_best_len;
    logic [VW-1:0]   r_lst_start, r_lst_len;
    logic            r_lst_used;
    logic [VW-1:0]   r_prv_start, r_prv_len;
    logic            r_prv_used;
    logic [VW-1:0]   r_nxt_len;
    logic            r_nxt_free;
    logic [1:0]      r_rm_n;
    logic [1:0]      r_status;
    logic [VW-1:0]   r_pay;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;

    logic [VW-1:0] e_start, e_len;
    logic          e_used;
    logic [TW:0]   i_p1, tot_x, sk_rm, best_p1;
    logic [5:0]    pk, lim;
    logic [VW-1:0] gap, cur_len;
    logic          merge_prev;

    bfha_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_tbl (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign e_start = rdata[EW-1:VW+1];
    assign e_len   = rdata[VW:1];
    assign e_used  = rdata[0];

    assign i_p1    = {1'b0, r_i} + 1'b1;
    assign tot_x   = {1'b0, r_total};
    assign best_p1 = {1'b0, r_best} + 1'b1;
    assign sk_rm   = {1'b0, r_sk} + (TW+1)'(r_rm_n);
    assign pk      = {1'b0, r_pages} + {1'b0, r_k};
    assign lim     = ({1'b0, r_limit} > C_MAXP) ? C_MAXP : {1'b0, r_limit};
    assign gap     = r_span_end - r_lst_start;
    assign cur_len = r_lst_len + (r_nxt_free ? (C_BO + r_nxt_len) : '0);
    assign merge_prev = (r_i != '0) && !r_prv_used;

    always_comb begin
        o_stat.found    = r_found;
        o_stat.lst_used = r_lst_used;
        o_stat.tbl_full = (r_total >= C_MAXB);
        o_stat.a_last   = (i_p1 == tot_x);
        o_stat.g_enough = (r_acc >= r_need);
        o_stat.g_over   = (pk >= lim);
        o_stat.split    = (r_best_len > r_size + C_BO) && (r_total < C_MAXB);
        o_stat.sh_more  = ({1'b0, r_sk} > best_p1);
        o_stat.match    = (e_start + C_BO == VW'(r_off));
        o_stat.rm_more  = (sk_rm < tot_x);
        o_stat.sk_back  = (r_i != '0) && !e_used;
        o_stat.pg_more  = (r_pages > PG_W'(1)) && (r_new_end + C_PAGE < r_span_end);
        o_stat.tr_skip  = (r_total == TW'(1)) || r_lst_used || (r_span_end <= r_lst_start);
        o_stat.tr_big   = (gap > C_BO);
    end

    // Table port selection per step
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = '0;
        case (i_cmd.op)
            OP_INIT: begin
                we    = 1'b1;
                wdata = {C_HEAD, C_PAGE - C_HEAD - C_BO, 1'b0};
            end
            OP_A_RD, OP_F_RD, OP_SK_RD: raddr = r_i[IW-1:0];
            OP_G_FREE: begin
                we    = 1'b1;
                waddr = IW'(r_total - 1'b1);
                wdata = {r_lst_start, r_lst_len + r_acc, 1'b0};
            end
            OP_G_NEW: begin
                we    = 1'b1;
                waddr = r_total[IW-1:0];
                wdata = {r_span_end, r_acc - C_BO, 1'b0};
            end
            OP_USE: begin
                we    = 1'b1;
                waddr = r_best[IW-1:0];
                wdata = {r_best_start, o_stat.split ? r_size : r_best_len, 1'b1};
            end
            OP_SH_RD: raddr = IW'(r_sk - 1'b1);
            OP_SH_WR: begin
                we    = 1'b1;
                waddr = r_sk[IW-1:0];
                wdata = rdata;
            end
            OP_INS_WR: begin
                we    = 1'b1;
                waddr = best_p1[IW-1:0];
                wdata = {r_best_start + C_BO + r_size, r_best_len - r_size - C_BO, 1'b0};
            end
            OP_N_RD: raddr = i_p1[IW-1:0];
            OP_MERGE: begin
                we = 1'b1;
                if (merge_prev) begin
                    waddr = IW'(r_i - 1'b1);
                    wdata = {r_prv_start, r_prv_len + C_BO + cur_len, 1'b0};
                end else begin
                    waddr = r_i[IW-1:0];
                    wdata = {r_lst_start, cur_len, 1'b0};
                end
            end
            OP_RM_RD: raddr = sk_rm[IW-1:0];
            OP_RM_WR: begin
                we    = 1'b1;
                waddr = r_sk[IW-1:0];
                wdata = rdata;
            end
            OP_TR_CHK: begin
                raddr = IW'(r_total - TW'(2));
                if (!o_stat.tr_skip && o_stat.tr_big) begin
                    we    = 1'b1;
                    waddr = IW'(r_total - 1'b1);
                    wdata = {r_lst_start, gap - C_BO, 1'b0};
                end
            end
            OP_TR_JOIN: begin
                we    = 1'b1;
                waddr = IW'(r_total - TW'(2));
                wdata = {e_start, e_len + gap, e_used};
            end
            default: ;
        endcase
    end

    // Control state: table size, heap span and the limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= TW'(1);
            r_pages    <= PG_W'(1);
            r_span_end <= C_PAGE;
            r_limit    <= PG_W'(16);
            r_found    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            case (i_cmd.op)
                OP_INIT: begin
                    r_total    <= TW'(1);
                    r_pages    <= PG_W'(1);
                    r_span_end <= C_PAGE;
                end
                OP_IDLE: r_found <= 1'b0;
                OP_A_CMP: begin
                    if (!e_used && e_len >= r_size && (!r_found || e_len < r_best_len)) begin
                        r_found <= 1'b1;
                    end
                end
                OP_G_FREE: begin
                    r_pages    <= r_pages + r_k;
                    r_span_end <= r_span_end + r_acc;
                end
                OP_G_NEW: begin
                    r_pages    <= r_pages + r_k;
                    r_span_end <= r_span_end + r_acc;
                    r_total    <= r_total + 1'b1;
                end
                OP_INS_WR:  r_total <= r_total + 1'b1;
                OP_RM_END:  r_total <= r_total - TW'(r_rm_n);
                OP_PG_STEP: begin
                    if (o_stat.pg_more) begin
                        r_pages    <= r_pages - 1'b1;
                        r_span_end <= r_span_end - C_PAGE;
                    end
                end
                OP_TR_JOIN: r_total <= r_total - 1'b1;
                default: ;
            endcase
        end
    end

    // Working registers of the current request
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_IDLE: begin
                r_size <= (VW'(i_request_bytes) + C_RND) & ~C_RND;
                r_off  <= i_free_offset;
                r_i    <= '0;
            end
            OP_A_CMP: begin
                r_lst_start <= e_start;
                r_lst_len   <= e_len;
                r_lst_used  <= e_used;
                r_i         <= r_i + 1'b1;
                if (!e_used && e_len >= r_size && (!r_found || e_len < r_best_len)) begin
                    r_best       <= r_i;
                    r_best_start <= e_start;
                    r_best_len   <= e_len;
                end
            end
            OP_G_SETUP: begin
                r_need <= r_lst_used ? (r_size + C_BO) : (r_size - r_lst_len);
                r_acc  <= '0;
                r_k    <= '0;
            end
            OP_G_STEP: begin
                if (!o_stat.g_enough && !o_stat.g_over) begin
                    r_acc <= r_acc + C_PAGE;
                    r_k   <= r_k + 1'b1;
                end
            end
            OP_G_FREE: begin
                r_best       <= r_total - 1'b1;
                r_best_start <= r_lst_start;
                r_best_len   <= r_lst_len + r_acc;
            end
            OP_G_NEW: begin
                r_best       <= r_total;
                r_best_start <= r_span_end;
                r_best_len   <= r_acc - C_BO;
            end
            OP_USE: begin
                r_status <= ST_OK;
                r_pay    <= r_best_start + C_BO;
                r_sk     <= r_total;
            end
            OP_SH_WR: r_sk <= r_sk - 1'b1;
            OP_F_CMP: begin
                if (o_stat.match) begin
                    r_lst_start <= e_start;
                    r_lst_len   <= e_len;
                    r_lst_used  <= e_used;
                end else begin
                    r_prv_start <= e_start;
                    r_prv_len   <= e_len;
                    r_prv_used  <= e_used;
                    r_i         <= r_i + 1'b1;
                end
            end
            OP_N_CAP: begin
                r_nxt_len  <= e_len;
                r_nxt_free <= (i_p1 < tot_x) && !e_used;
            end
            OP_MERGE: begin
                r_status <= ST_OK;
                r_pay    <= '0;
                if (merge_prev) begin
                    r_sk   <= r_i;
                    r_rm_n <= r_nxt_free ? 2'd2 : 2'd1;
                end else begin
                    r_sk   <= i_p1[TW-1:0];
                    r_rm_n <= r_nxt_free ? 2'd1 : 2'd0;
                end
            end
            OP_RM_WR:  r_sk <= r_sk + 1'b1;
            OP_RM_END: r_i  <= r_total - TW'(r_rm_n) - 1'b1;
            OP_SK_CMP: begin
                if (r_i == r_total - 1'b1) begin
                    r_lst_start <= e_start;
                    r_lst_len   <= e_len;
                    r_lst_used  <= e_used;
                end
                if (o_stat.sk_back) begin
                    r_i <= r_i - 1'b1;
                end else begin
                    r_new_end <= e_start + C_BO + e_len;
                end
            end
            OP_FAIL_NS: begin
                r_status <= ST_NO_SPACE;
                r_pay    <= '0;
            end
            OP_FAIL_NB: begin
                r_status <= ST_NO_BLOCK;
                r_pay    <= '0;
            end
            default: ;
        endcase
    end

    assign o_status          = r_status;
    assign o_payload_offset  = r_pay[15:0];
    assign o_pages_in_use    = r_pages;
    assign o_blocks_in_table = 7'(r_total);
endmodule

// File: rtl/best_fit_heap_allocator_top.sv
// Allocate: a best-fit scan reads every table entry; if none fits, the last free block
//   grows by whole pages or a new block is added at the end; a split moves entries up.
// Free: search for the entry, merge with free neighbours, move later entries down, walk back
//   to the last used block, release spare pages and trim the end; a bad offset fails.
// One request at a time, set by the sequencer; o_done pulses once per request.
// Synchronous active-low reset; after reset the INIT step writes the first entry, busy high.
module best_fit_heap_allocator_top #(
    parameter int PAGE_BYTES     = 4096,
    parameter int MAX_PAGES      = 16,
    parameter int MAX_BLOCKS     = 64,
    parameter int BLOCK_OVERHEAD = 32,
    parameter int HEAD_OVERHEAD  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_action,
    input  logic [15:0] i_request_bytes,
    input  logic [15:0] i_free_offset,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [15:0] o_payload_offset,
    output logic [4:0]  o_pages_in_use,
    output logic [6:0]  o_blocks_in_table,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);
    import bfha_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  busy;

    // Take limit writes only while idle, so a request sees one limit throughout.
    assign o_cfg_ready = !busy;
    assign o_busy      = busy;

    // Sequence the request: scan, grow, split, merge, release and trim.
    bfha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_action(i_action),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // Hold the block table, heap span and per-request working registers.
    bfha_dp #(
        .PAGE_BYTES    (PAGE_BYTES),
        .MAX_PAGES     (MAX_PAGES),
        .MAX_BLOCKS    (MAX_BLOCKS),
        .BLOCK_OVERHEAD(BLOCK_OVERHEAD),
        .HEAD_OVERHEAD (HEAD_OVERHEAD)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_valid & o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_request_bytes  (i_request_bytes),
        .i_free_offset    (i_free_offset),
        .o_status         (o_status),
        .o_payload_offset (o_payload_offset),
        .o_pages_in_use   (o_pages_in_use),
        .o_blocks_in_table(o_blocks_in_table)
    );
endmodule

// File: rtl/bfha_chk.sv
module bfha_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_done,
    input logic [1:0]  o_status,
    input logic [15:0] o_payload_offset,
    input logic [4:0]  o_pages_in_use
);
    import bfha_pkg::*;

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy) else $error("result outside a request");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("request not taken");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_payload_offset == 16'd0))
        else $error("failed request carries an offset");

    a_pages: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_pages_in_use != 5'd0 && o_status != 2'd3))
        else $error("bad page count or status");
endmodule

bind best_fit_heap_allocator_top bfha_chk u_chk (.*);

// File: tb/tb.sv
`timescale 1ns / 100ps

import bfha_pkg::*;

typedef struct {
    logic [1:0]  status;
    logic [15:0] pay;
    logic [4:0]  pages;
    logic [6:0]  blocks;
} t_grant;

class alloc_scoreboard;
    localparam int PG    = 4096;
    localparam int NPG   = 16;
    localparam int NBLK  = 64;
    localparam int DESC  = 32;
    localparam int HEAD  = 16;

    int unsigned blk_start [NBLK];
    int unsigned blk_len   [NBLK];
    bit          blk_used  [NBLK];
    int unsigned blk_cnt;
    int unsigned pg_cnt;
    logic [4:0]  pg_limit;
    t_grant      pending [$];
    int          mismatches;

    function void clear();
        foreach (blk_start[i]) begin
            blk_start[i] = 0;
            blk_len[i]   = 0;
            blk_used[i]  = 0;
        end
        blk_start[0] = HEAD;
        blk_len[0]   = PG - HEAD - DESC;
        blk_cnt      = 1;
        pg_cnt       = 1;
        pg_limit     = 5'd16;
        mismatches   = 0;
    endfunction

    function void open_slot(int unsigned at, int unsigned st, int unsigned len);
        if (blk_cnt >= NBLK || at > blk_cnt) return;
        for (int unsigned k = blk_cnt; k > at; k--) begin
            blk_start[k] = blk_start[k-1];
            blk_len[k]   = blk_len[k-1];
            blk_used[k]  = blk_used[k-1];
        end
        blk_start[at] = st;
        blk_len[at]   = len;
        blk_used[at]  = 0;
        blk_cnt++;
    endfunction

    function void close_slot(int unsigned at);
        if (at >= blk_cnt || blk_cnt <= 1) return;
        for (int unsigned k = at; k + 1 < blk_cnt; k++) begin
            blk_start[k] = blk_start[k+1];
            blk_len[k]   = blk_len[k+1];
            blk_used[k]  = blk_used[k+1];
        end
        blk_cnt--;
    endfunction

    function int unsigned pages_for(int unsigned bytes);
        return (bytes + PG - 1) / PG;
    endfunction

    // best fit, grow at the end if nothing fits, then split the remainder
    function logic [1:0] grant_block(int unsigned req, output int unsigned pay);
        int unsigned size, lim, best, k, last, rem;
        bit found;
        size  = (req + 7) & ~32'd7;
        lim   = (pg_limit < NPG) ? pg_limit : NPG;
        found = 0;
        best  = NBLK;
        pay   = 0;
        for (int unsigned i = 0; i < blk_cnt; i++)
            if (!blk_used[i] && blk_len[i] >= size &&
                (!found || blk_len[i] < blk_len[best])) begin
                best  = i;
                found = 1;
            end
        if (!found) begin
            last = blk_cnt - 1;
            if (!blk_used[last]) begin
                k = pages_for(size - blk_len[last]);
                if (pg_cnt + k > lim) return ST_NO_SPACE;
                blk_len[last] += k * PG;
                pg_cnt += k;
                best = last;
            end else begin
                if (blk_cnt >= NBLK) return ST_NO_SPACE;
                k = pages_for(size + DESC);
                if (pg_cnt + k > lim) return ST_NO_SPACE;
                open_slot(blk_cnt, pg_cnt * PG, k * PG - DESC);
                pg_cnt += k;
                best = blk_cnt - 1;
            end
        end
        blk_used[best] = 1;
        if (blk_len[best] > size + DESC && blk_cnt < NBLK) begin
            rem = blk_len[best] - size - DESC;
            open_slot(best + 1, blk_start[best] + DESC + size, rem);
            blk_len[best] = size;
        end
        pay = blk_start[best] + DESC;
        return ST_OK;
    endfunction

    function void pull_back_heap();
        int unsigned j, new_end, span_end, last, gap;
        j = blk_cnt - 1;
        while (j > 0 && !blk_used[j]) j--;
        new_end  = blk_start[j] + DESC + blk_len[j];
        span_end = pg_cnt * PG;
        while (pg_cnt > 1 && new_end + PG < span_end) begin
            pg_cnt--;
            span_end -= PG;
        end
        last = blk_cnt - 1;
        if (last == 0 || blk_used[last] || span_end <= blk_start[last]) return;
        gap = span_end - blk_start[last];
        if (gap > DESC) begin
            blk_len[last] = gap - DESC;
        end else begin
            blk_len[last-1] += gap;
            close_slot(last);
        end
    endfunction

    function logic [1:0] release_block(int unsigned off);
        int unsigned i;
        for (i = 0; i < blk_cnt; i++)
            if (blk_start[i] + DESC == off) break;
        if (i >= blk_cnt) return ST_NO_BLOCK;
        blk_used[i] = 0;
        if (i + 1 < blk_cnt && !blk_used[i+1]) begin
            blk_len[i] += DESC + blk_len[i+1];
            close_slot(i + 1);
        end
        if (i > 0 && !blk_used[i-1]) begin
            blk_len[i-1] += DESC + blk_len[i];
            close_slot(i);
        end
        pull_back_heap();
        return ST_OK;
    endfunction

    function t_grant note_request(logic act, logic [15:0] req, logic [15:0] off);
        t_grant g;
        int unsigned pay;
        pay = 0;
        if (act == ACT_ALLOC) g.status = grant_block(req, pay);
        else                  g.status = release_block(off);
        g.pay    = (g.status == ST_OK) ? pay[15:0] : 16'd0;
        g.pages  = pg_cnt[4:0];
        g.blocks = blk_cnt[6:0];
        pending.push_back(g);
        return g;
    endfunction

    function void check_result(logic [1:0] st, logic [15:0] pay, logic [4:0] pg,
                               logic [6:0] nb);
        t_grant g;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result st=%0d pay=%0d", st, pay);
            return;
        end
        g = pending.pop_front();
        if (st !== g.status || pay !== g.pay || pg !== g.pages || nb !== g.blocks) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch: exp st=%0d pay=%0d pg=%0d nb=%0d ",
                          "got st=%0d pay=%0d pg=%0d nb=%0d"},
                         g.status, g.pay, g.pages, g.blocks, st, pay, pg, nb);
        end
    endfunction
endclass

module tb;
    localparam int CYCLE_LIMIT = 3000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic        i_action;
    logic [15:0] i_request_bytes;
    logic [15:0] i_free_offset;
    logic        o_done;
    logic [1:0]  o_status;
    logic [15:0] o_payload_offset;
    logic [4:0]  o_pages_in_use;
    logic [6:0]  o_blocks_in_table;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data;

    alloc_scoreboard heap_sb;
    int              cycles = 0;
    int              idle_pct;
    logic [15:0]     live_offs [$];
    logic [15:0]     stale_offs [$];

    best_fit_heap_allocator_top u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_action          (i_action),
        .i_request_bytes   (i_request_bytes),
        .i_free_offset     (i_free_offset),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_payload_offset  (o_payload_offset),
        .o_pages_in_use    (o_pages_in_use),
        .o_blocks_in_table (o_blocks_in_table),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Watchdog: bail out if the block hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Results cannot be held off: check each one on the edge that ends its strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            heap_sb.check_result(o_status, o_payload_offset, o_pages_in_use,
                                 o_blocks_in_table);
    end

    // Present one request, hold it until taken, then maybe idle for a while.
    // start is left high when no gap follows, so the next request never
    // lowers and raises it within one step.
    task automatic issue_request(logic act, logic [15:0] req, logic [15:0] off);
        t_grant g;
        int     k;
        i_start         <= 1'b1;
        i_action        <= act;
        i_request_bytes <= req;
        i_free_offset   <= off;
        do @(posedge i_clk); while (o_busy);
        g = heap_sb.note_request(act, req, off);
        // track granted payloads so that most frees name a real block
        if (g.status == ST_OK && act == ACT_ALLOC) live_offs.push_back(g.pay);
        if (g.status == ST_OK && act == ACT_FREE) begin
            for (k = 0; k < live_offs.size(); k++)
                if (live_offs[k] == off) begin
                    live_offs.delete(k);
                    break;
                end
            stale_offs.push_back(off);
            if (stale_offs.size() > 16) void'(stale_offs.pop_front());
        end
        if ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // Drop start and let every outstanding result come back
    task automatic wait_drained();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (heap_sb.pending.size() != 0 || o_busy) @(posedge i_clk);
    endtask

    task automatic write_page_limit(logic [4:0] lim);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lim;
        do @(posedge i_clk); while (!o_cfg_ready);
        heap_sb.pg_limit = lim;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 16'($urandom_range(0, 200));
        if (r < 90) return 16'($urandom_range(201, 3000));
        if (r < 97) return 16'($urandom_range(3001, 20000));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_free();
        int r;
        r = $urandom_range(99);
        if (r < 80 && live_offs.size() != 0)
            return live_offs[$urandom_range(0, live_offs.size() - 1)];
        if (r < 90 && stale_offs.size() != 0)
            return stale_offs[$urandom_range(0, stale_offs.size() - 1)];
        return 16'($urandom);
    endfunction

    initial begin
        logic [4:0] limits [6] = '{5'd1, 5'd16, 5'd3, 5'd9, 5'd2, 5'd16};
        int         phase_idle [6] = '{0, 62, 18, 62, 0, 18};
        logic [15:0] keep;

        heap_sb  = new();
        heap_sb.clear();
        idle_pct        = 0;
        i_rst_n         = 1'b0;
        i_start         = 1'b0;
        i_action        = ACT_ALLOC;
        i_request_bytes = '0;
        i_free_offset   = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);

        // Directed part: size extremes, growth, limit, bad and repeated frees
        write_page_limit(5'd16);
        issue_request(ACT_ALLOC, 16'd0, 16'hFFFF);
        issue_request(ACT_ALLOC, 16'd1, 16'd0);
        issue_request(ACT_ALLOC, 16'hFFFF, 16'd0);
        issue_request(ACT_ALLOC, 16'd4000, 16'd0);
        keep = live_offs[live_offs.size() - 1];
        issue_request(ACT_ALLOC, 16'd9000, 16'd0);
        issue_request(ACT_FREE, 16'hFFFF, 16'd0);
        issue_request(ACT_FREE, 16'd0, 16'hFFFF);
        issue_request(ACT_FREE, 16'd0, 16'd33);
        issue_request(ACT_FREE, 16'd0, keep);
        issue_request(ACT_FREE, 16'd0, keep);
        issue_request(ACT_ALLOC, 16'd3992, 16'd0);
        issue_request(ACT_ALLOC, 16'd60000, 16'd0);
        while (live_offs.size() != 0)
            issue_request(ACT_FREE, 16'($urandom), live_offs[0]);
        wait_drained();
        write_page_limit(5'd1);
        issue_request(ACT_ALLOC, 16'd4048, 16'd0);
        issue_request(ACT_ALLOC, 16'd4049, 16'd0);
        issue_request(ACT_ALLOC, 16'd8, 16'd0);
        issue_request(ACT_FREE, 16'd0, 16'd48);

        // Random part: phases with different page limits and sender gaps
        for (int p = 0; p < 6; p++) begin
            wait_drained();
            write_page_limit(limits[p]);
            idle_pct = phase_idle[p];
            for (int n = 0; n < 200; n++) begin
                if (live_offs.size() != 0 && $urandom_range(99) < 45)
                    issue_request(ACT_FREE, 16'($urandom), pick_free());
                else
                    issue_request(ACT_ALLOC, pick_size(), 16'($urandom));
            end
        end

        wait_drained();
        repeat (400) @(posedge i_clk);
        if (heap_sb.mismatches == 0 && heap_sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/bfha_pkg.sv
rtl/bfha_ram.sv
rtl/bfha_ctrl.sv
rtl/bfha_dp.sv
rtl/best_fit_heap_allocator_top.sv
rtl/bfha_chk.sv
tb/tb.sv
